// File: rtl/mevs_pkg.sv
// Shared types and constants for the MUS event voice sequencer.
// Used by mevs_ctrl, mevs_datapath and the top level; no dependencies.
package mevs_pkg;

    localparam int CHANNELS     = 16;
    localparam int CH_W         = 4;
    localparam int NOTE_W       = 7;
    localparam int VOL_W        = 7;
    localparam int INST_W       = 8;
    localparam int VOICE_W      = 4;
    localparam int TICKS_W      = 28;
    localparam int MAX_RESULTS  = 9;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int TDATA_W      = 64;

    localparam int PERC_CHANNEL = 15;
    localparam int PERC_MOD     = 47;
    localparam int PERC_BASE    = 128;
    localparam int VOL_MAX      = 127;
    localparam int VOL_RESET    = 100;

    localparam logic [7:0] SYS_OFF_A    = 8'd11;
    localparam logic [7:0] SYS_OFF_B    = 8'd14;
    localparam logic [7:0] CTRL_INSTR   = 8'd0;
    localparam logic [7:0] CTRL_VOLUME  = 8'd3;

    // event type field of an event byte (bits 6..4)
    localparam logic [2:0] EV_RELEASE = 3'd0;
    localparam logic [2:0] EV_PLAY    = 3'd1;
    localparam logic [2:0] EV_PITCH   = 3'd2;
    localparam logic [2:0] EV_SYSTEM  = 3'd3;
    localparam logic [2:0] EV_CONTROL = 3'd4;
    localparam logic [2:0] EV_MEASURE = 3'd5;

    typedef enum logic [1:0] {
        KIND_KEY_ON  = 2'd0,
        KIND_KEY_OFF = 2'd1,
        KIND_DELAY   = 2'd2,
        KIND_LOOP    = 2'd3
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic load_byte;
        logic set_event;
        logic set_note;
        logic set_vol;
        logic set_ctrl_num;
        logic ctrl_write;
        logic key_on;
        logic emit_loop;
        logic delay_step;
        logic delay_emit;
        logic scan_start;
        logic scan_by_note;
        logic scan_step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       byte_msb;
        logic [2:0] byte_type;
        logic       sys_off;
        logic       scan_busy;
        logic       scan_emit;
        logic       out_free;
    } sts_t;

    // 128 + note mod 47, note below 141 so two conditional subtracts suffice
    function automatic logic [INST_W-1:0] perc_instrument(input logic [NOTE_W-1:0] note);
        logic [NOTE_W-1:0] r;
        r = note;
        if (r >= NOTE_W'(2 * PERC_MOD)) begin
            r = r - NOTE_W'(2 * PERC_MOD);
        end else if (r >= NOTE_W'(PERC_MOD)) begin
            r = r - NOTE_W'(PERC_MOD);
        end
        return INST_W'(PERC_BASE) + INST_W'(r);
    endfunction

endpackage

// File: rtl/mevs_ctrl.sv
// Sequencing controller: score parse phase, per-item state machine and
// command generation for the datapath. Depends on mevs_pkg.
module mevs_ctrl
    import mevs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_KEYON = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

    typedef enum logic [8:0] {
        PH_EVENT     = 9'b000000001,
        PH_REL_NOTE  = 9'b000000010,
        PH_PLAY_NOTE = 9'b000000100,
        PH_PLAY_VOL  = 9'b000001000,
        PH_PITCH_ARG = 9'b000010000,
        PH_SYS_ARG   = 9'b000100000,
        PH_CTRL_NUM  = 9'b001000000,
        PH_CTRL_VAL  = 9'b010000000,
        PH_DELAY     = 9'b100000000
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   last_reg, last_next;
    phase_t fin;

    assign s_tready = (state_reg == ST_IDLE);
    assign fin      = last_reg ? PH_DELAY : PH_EVENT;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_byte = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (phase_reg)
                    PH_EVENT: begin
                        unique case (sts.byte_type)
                            EV_RELEASE: begin
                                cmd.set_event = 1'b1;
                                last_next     = sts.byte_msb;
                                phase_next    = PH_REL_NOTE;
                                state_next    = ST_IDLE;
                            end
                            EV_PLAY: begin
                                cmd.set_event = 1'b1;
                                last_next     = sts.byte_msb;
                                phase_next    = PH_PLAY_NOTE;
                                state_next    = ST_IDLE;
                            end
                            EV_PITCH: begin
                                cmd.set_event = 1'b1;
                                last_next     = sts.byte_msb;
                                phase_next    = PH_PITCH_ARG;
                                state_next    = ST_IDLE;
                            end
                            EV_SYSTEM: begin
                                cmd.set_event = 1'b1;
                                last_next     = sts.byte_msb;
                                phase_next    = PH_SYS_ARG;
                                state_next    = ST_IDLE;
                            end
                            EV_CONTROL: begin
                                cmd.set_event = 1'b1;
                                last_next     = sts.byte_msb;
                                phase_next    = PH_CTRL_NUM;
                                state_next    = ST_IDLE;
                            end
                            EV_MEASURE: begin
                                cmd.set_event = 1'b1;
                                last_next     = sts.byte_msb;
                                phase_next    = sts.byte_msb ? PH_DELAY : PH_EVENT;
                                state_next    = ST_IDLE;
                            end
                            default: begin
                                // score end: loop result, last bit dropped
                                if (sts.out_free) begin
                                    cmd.set_event = 1'b1;
                                    cmd.emit_loop = 1'b1;
                                    last_next     = 1'b0;
                                    phase_next    = PH_EVENT;
                                    state_next    = ST_IDLE;
                                end
                            end
                        endcase
                    end
                    PH_REL_NOTE: begin
                        cmd.scan_start   = 1'b1;
                        cmd.scan_by_note = 1'b1;
                        phase_next       = fin;
                        state_next       = ST_SCAN;
                    end
                    PH_PLAY_NOTE: begin
                        cmd.set_note = 1'b1;
                        if (sts.byte_msb) begin
                            phase_next = PH_PLAY_VOL;
                            state_next = ST_IDLE;
                        end else begin
                            phase_next = fin;
                            state_next = ST_KEYON;
                        end
                    end
                    PH_PLAY_VOL: begin
                        cmd.set_vol = 1'b1;
                        phase_next  = fin;
                        state_next  = ST_KEYON;
                    end
                    PH_PITCH_ARG: begin
                        phase_next = fin;
                        state_next = ST_IDLE;
                    end
                    PH_SYS_ARG: begin
                        phase_next = fin;
                        if (sts.sys_off) begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    PH_CTRL_NUM: begin
                        cmd.set_ctrl_num = 1'b1;
                        phase_next       = PH_CTRL_VAL;
                        state_next       = ST_IDLE;
                    end
                    PH_CTRL_VAL: begin
                        cmd.ctrl_write = 1'b1;
                        phase_next     = fin;
                        state_next     = ST_IDLE;
                    end
                    PH_DELAY: begin
                        if (sts.byte_msb) begin
                            cmd.delay_step = 1'b1;
                            state_next     = ST_IDLE;
                        end else if (sts.out_free) begin
                            cmd.delay_step = 1'b1;
                            cmd.delay_emit = 1'b1;
                            last_next      = 1'b0;
                            phase_next     = PH_EVENT;
                            state_next     = ST_IDLE;
                        end
                    end
                    default: begin
                        phase_next = PH_EVENT;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_KEYON: begin
                if (sts.out_free) begin
                    cmd.key_on = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!sts.scan_busy) begin
                    state_next = ST_IDLE;
                end else if (!sts.scan_emit || sts.out_free) begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_EVENT;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
        end
    end

    // the delay phase is only ever entered from an event with its last bit set
    a_delay_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DELAY) |-> last_reg)
        else $error("delay phase without pending last bit");

    // key-on and voice scan run after the event's argument bytes are consumed
    a_keyon_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KEYON) |-> (phase_reg == PH_EVENT || phase_reg == PH_DELAY))
        else $error("key-on with parse still mid-event");

    a_scan_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (phase_reg == PH_EVENT || phase_reg == PH_DELAY))
        else $error("voice scan with parse still mid-event");

endmodule

// File: rtl/mevs_datapath.sv
// Datapath: pending event fields, channel tables, voice table, delay
// accumulator, voice pick / release scan and the result register. Uses mevs_pkg.
module mevs_datapath
    import mevs_pkg::*;
#(
    parameter int VOICES     = 9,
    parameter int DELAY_BITS = 28
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_tdata,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;

    function automatic logic [VIW-1:0] first_set(input logic [VOICES-1:0] v);
        logic [VIW-1:0] r;
        r = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = VIW'(i);
            end
        end
        return r;
    endfunction

    // event state
    logic [7:0]             byte_reg, byte_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [NOTE_W-1:0]      note_reg, note_next;
    logic [7:0]             ctrl_reg, ctrl_next;
    logic [DELAY_BITS-1:0]  delay_reg, delay_next;

    // channel tables
    logic [7:0] inst_reg [CHANNELS];
    logic [7:0] inst_next [CHANNELS];
    logic [7:0] vol_reg [CHANNELS];
    logic [7:0] vol_next [CHANNELS];

    // voice table
    logic [VOICES-1:0]  act_reg, act_next;
    logic [CH_W-1:0]    vch_reg [VOICES];
    logic [CH_W-1:0]    vch_next [VOICES];
    logic [NOTE_W-1:0]  vnote_reg [VOICES];
    logic [NOTE_W-1:0]  vnote_next [VOICES];

    // release scan
    logic [VOICES-1:0]  mask_reg, mask_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // result register
    logic                  ovalid_reg, ovalid_next;
    kind_t                 okind_reg, okind_next;
    logic [VOICE_W-1:0]    ovoice_reg, ovoice_next;
    logic                  ostolen_reg, ostolen_next;
    logic [CH_W-1:0]       och_reg, och_next;
    logic [NOTE_W-1:0]     onote_reg, onote_next;
    logic [VOL_W-1:0]      ovol_reg, ovol_next;
    logic [INST_W-1:0]     oinst_reg, oinst_next;
    logic [TICKS_W-1:0]    oticks_reg, oticks_next;
    logic                  olast_reg, olast_next;

    logic                       out_free;
    logic                       emit;
    logic [DELAY_BITS+6:0]      dly_wide;
    logic [DELAY_BITS-1:0]      dly_acc;
    logic [VOICES-1:0]          match, free_v, same_v, other_v;
    logic [VIW-1:0]             pick_idx, scan_idx;
    logic [VOICES-1:0]          scan_rest;
    logic                       scan_emit;
    logic [7:0]                 ch_vol, ch_inst;
    logic [VOL_W-1:0]           kon_vol;
    logic [INST_W-1:0]          kon_inst;

    assign out_free = !ovalid_reg || m_tready;

    // delay: shift in 7 bits, saturate if anything spills past DELAY_BITS
    assign dly_wide = {delay_reg, byte_reg[6:0]};
    assign dly_acc  = (|dly_wide[DELAY_BITS+6:DELAY_BITS]) ? '1 : dly_wide[DELAY_BITS-1:0];

    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            match[i]   = act_reg[i] && (vch_reg[i] == ch_reg)
                         && (!cmd.scan_by_note || (vnote_reg[i] == byte_reg[6:0]));
            free_v[i]  = !act_reg[i];
            same_v[i]  = (vch_reg[i] == ch_reg) && (vnote_reg[i] == note_reg);
            other_v[i] = (vch_reg[i] != ch_reg);
        end
    end

    always_comb begin
        priority if (|free_v) begin
            pick_idx = first_set(free_v);
        end else if (|same_v) begin
            pick_idx = first_set(same_v);
        end else if (|other_v) begin
            pick_idx = first_set(other_v);
        end else begin
            pick_idx = '0;
        end
    end

    assign scan_idx  = first_set(mask_reg);
    assign scan_rest = mask_reg & ~(VOICES'(1) << scan_idx);
    assign scan_emit = (cnt_reg < CNT_W'(MAX_RESULTS));

    assign ch_vol   = vol_reg[ch_reg];
    assign ch_inst  = inst_reg[ch_reg];
    assign kon_vol  = (ch_vol > 8'(VOL_MAX)) ? VOL_W'(VOL_MAX) : ch_vol[VOL_W-1:0];
    assign kon_inst = (ch_reg == CH_W'(PERC_CHANNEL)) ? perc_instrument(note_reg)
                    : (ch_inst[7] ? '0 : ch_inst);

    assign emit = cmd.emit_loop || cmd.delay_emit || cmd.key_on
                  || (cmd.scan_step && scan_emit);

    always_comb begin
        byte_next  = byte_reg;
        ch_next    = ch_reg;
        note_next  = note_reg;
        ctrl_next  = ctrl_reg;
        delay_next = delay_reg;
        inst_next  = inst_reg;
        vol_next   = vol_reg;
        act_next   = act_reg;
        vch_next   = vch_reg;
        vnote_next = vnote_reg;
        mask_next  = mask_reg;
        cnt_next   = cnt_reg;

        ovalid_next  = ovalid_reg && !m_tready;
        okind_next   = okind_reg;
        ovoice_next  = ovoice_reg;
        ostolen_next = ostolen_reg;
        och_next     = och_reg;
        onote_next   = onote_reg;
        ovol_next    = ovol_reg;
        oinst_next   = oinst_reg;
        oticks_next  = oticks_reg;
        olast_next   = olast_reg;

        if (emit) begin
            ovalid_next  = 1'b1;
            ovoice_next  = '0;
            ostolen_next = 1'b0;
            och_next     = ch_reg;
            onote_next   = '0;
            ovol_next    = '0;
            oinst_next   = '0;
            oticks_next  = '0;
            olast_next   = 1'b1;
        end

        if (cmd.load_byte) begin
            byte_next = s_tdata;
        end
        if (cmd.set_event) begin
            ch_next = byte_reg[CH_W-1:0];
        end
        if (cmd.set_note) begin
            note_next = byte_reg[6:0];
        end
        if (cmd.set_vol) begin
            vol_next[ch_reg] = byte_reg;
        end
        if (cmd.set_ctrl_num) begin
            ctrl_next = byte_reg;
        end
        if (cmd.ctrl_write) begin
            if (ctrl_reg == CTRL_INSTR) begin
                inst_next[ch_reg] = byte_reg;
            end else if (ctrl_reg == CTRL_VOLUME) begin
                vol_next[ch_reg] = byte_reg;
            end
        end

        if (cmd.emit_loop) begin
            okind_next = KIND_LOOP;
            och_next   = byte_reg[CH_W-1:0];
        end

        if (cmd.delay_step) begin
            delay_next = dly_acc;
        end
        if (cmd.delay_emit) begin
            okind_next  = KIND_DELAY;
            oticks_next = TICKS_W'(dly_acc);
            delay_next  = '0;
        end

        if (cmd.key_on) begin
            act_next[pick_idx]   = 1'b1;
            vch_next[pick_idx]   = ch_reg;
            vnote_next[pick_idx] = note_reg;
            okind_next   = KIND_KEY_ON;
            ovoice_next  = VOICE_W'(pick_idx);
            ostolen_next = act_reg[pick_idx];
            onote_next   = note_reg;
            ovol_next    = kon_vol;
            oinst_next   = kon_inst;
        end

        if (cmd.scan_start) begin
            mask_next = match;
            cnt_next  = '0;
        end
        if (cmd.scan_step) begin
            act_next[scan_idx] = 1'b0;
            mask_next          = scan_rest;
            if (scan_emit) begin
                cnt_next    = cnt_reg + CNT_W'(1);
                okind_next  = KIND_KEY_OFF;
                ovoice_next = VOICE_W'(scan_idx);
                onote_next  = vnote_reg[scan_idx];
                // result cap reached or no further voice to release
                olast_next  = (scan_rest == '0) || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg     <= '0;
            note_reg   <= '0;
            ctrl_reg   <= '0;
            delay_reg  <= '0;
            act_reg    <= '0;
            mask_reg   <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                inst_reg[c] <= '0;
                vol_reg[c]  <= 8'(VOL_RESET);
            end
            for (int v = 0; v < VOICES; v++) begin
                vch_reg[v]   <= '0;
                vnote_reg[v] <= '0;
            end
        end else begin
            ch_reg     <= ch_next;
            note_reg   <= note_next;
            ctrl_reg   <= ctrl_next;
            delay_reg  <= delay_next;
            act_reg    <= act_next;
            mask_reg   <= mask_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
            inst_reg   <= inst_next;
            vol_reg    <= vol_next;
            vch_reg    <= vch_next;
            vnote_reg  <= vnote_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        okind_reg   <= okind_next;
        ovoice_reg  <= ovoice_next;
        ostolen_reg <= ostolen_next;
        och_reg     <= och_next;
        onote_reg   <= onote_next;
        ovol_reg    <= ovol_next;
        oinst_reg   <= oinst_next;
        oticks_reg  <= oticks_next;
        olast_reg   <= olast_next;
    end

    assign sts.byte_msb  = byte_reg[7];
    assign sts.byte_type = byte_reg[6:4];
    assign sts.sys_off   = (byte_reg == SYS_OFF_A) || (byte_reg == SYS_OFF_B);
    assign sts.scan_busy = |mask_reg;
    assign sts.scan_emit = scan_emit;
    assign sts.out_free  = out_free;

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = TDATA_W'({oticks_reg, oinst_reg, ovol_reg, onote_reg,
                                och_reg, ostolen_reg, ovoice_reg});

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!ovalid_reg || m_tready))
        else $error("result register overwritten while held");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("key-off result count past cap");

    a_keyon_active: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.key_on |=> act_reg[$past(pick_idx)])
        else $error("picked voice not marked active");

endmodule

// File: rtl/mus_event_voice_sequencer.sv
// MUS score event sequencer with synth voice allocation. Takes one score byte
// per item and returns key-on, key-off, delay and loop results through a
// single output register. Each byte is accepted, then executed; a play
// event adds a voice pick, and a release or system key-off adds a release
// scan that clears the matching voices one voice per cycle, holding while a
// key-off result waits on the output register. Any result waits for the
// output register to drain before it is written. Channel tables and the
// voice table are set directly by reset; no clearing pass.
// Depends on mevs_pkg, mevs_ctrl, mevs_datapath.
module mus_event_voice_sequencer
    import mevs_pkg::*;
#(
    parameter int VOICES     = 9,
    parameter int DELAY_BITS = 28
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] stream_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [3:0] voice, [4] stolen, [8:5] midi_channel, [15:9] note,
    // [22:16] volume, [30:23] instrument, [58:31] delay_ticks, [63:59] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,    // [1:0] kind
    output logic               m_tlast
);

    cmd_t cmd;
    sts_t sts;

    mevs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mevs_datapath #(
        .VOICES     (VOICES),
        .DELAY_BITS (DELAY_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/tb_mus_event_voice_sequencer.sv
// Self-checking testbench for mus_event_voice_sequencer: drives MUS score bytes
// and checks every key-on, key-off, delay and loop item against a local model.
// Depends on mevs_pkg and the RTL of the sequencer.
`timescale 1ns / 100ps

module tb_mus_event_voice_sequencer
    import mevs_pkg::*;
();

    localparam int VOICES       = 9;
    localparam int DELAY_BITS   = 28;
    localparam logic [63:0] DELAY_MAX = (64'd1 << DELAY_BITS) - 64'd1;
    localparam logic [2:0] EV_END_A = 3'd6;
    localparam logic [2:0] EV_END_B = 3'd7;
    // release scan of all voices plus a full output stall fits well inside this
    localparam int SETTLE_CYCLES = 64;

    typedef enum logic [3:0] {
        ST_EVENT, ST_REL_NOTE, ST_PLAY_NOTE, ST_PLAY_VOL, ST_PITCH_ARG,
        ST_SYS_ARG, ST_CTRL_NUM, ST_CTRL_VAL, ST_DELAY
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  voice;
        logic        stolen;
        logic [3:0]  chan;
        logic [6:0]  note;
        logic [6:0]  vol;
        logic [7:0]  inst;
        logic [27:0] ticks;
        logic        last;
    } seq_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    mus_event_voice_sequencer #(
        .VOICES    (VOICES),
        .DELAY_BITS(DELAY_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // sequencer model state
    parse_state_t parse_st;
    logic [3:0]   pend_ch;
    logic [6:0]   pend_note;
    logic         pend_last;
    logic [7:0]   pend_ctrl;
    logic [27:0]  delay_acc;
    logic [7:0]   chan_inst [CHANNELS];
    logic [7:0]   chan_vol [CHANNELS];
    logic         voice_on [VOICES];
    logic [3:0]   voice_ch [VOICES];
    logic [7:0]   voice_nt [VOICES];

    seq_result_t byte_results[$];
    seq_result_t expected_events[$];

    int bytes_sent;
    int results_seen;
    int fail_count;
    int n_key_on, n_steal, n_key_off, n_delay, n_loop;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results still outstanding", expected_events.size());
        $display("tb_mus_event_voice_sequencer: FAIL");
        $finish;
    end

    // ---------------- model ----------------

    function automatic void add_result(input kind_t kind, input logic [3:0] voice,
                                       input logic stolen, input logic [3:0] chan,
                                       input logic [6:0] note, input logic [6:0] vol,
                                       input logic [7:0] inst, input logic [27:0] ticks);
        seq_result_t r;
        if (byte_results.size() >= MAX_RESULTS) begin
            return;
        end
        r = '{kind, voice, stolen, chan, note, vol, inst, ticks, 1'b0};
        byte_results.push_back(r);
    endfunction

    function automatic void end_event();
        parse_st = pend_last ? ST_DELAY : ST_EVENT;
    endfunction

    function automatic void release_voices(input logic [3:0] ch, input logic by_note,
                                           input logic [6:0] note);
        for (int i = 0; i < VOICES; i++) begin
            if (voice_on[i] && voice_ch[i] == ch && (!by_note || voice_nt[i] == {1'b0, note})) begin
                voice_on[i] = 1'b0;
                add_result(KIND_KEY_OFF, 4'(i), 1'b0, ch, voice_nt[i][6:0], '0, '0, '0);
            end
        end
    endfunction

    function automatic int pick_voice(input logic [3:0] ch, input logic [6:0] note);
        for (int i = 0; i < VOICES; i++) begin
            if (!voice_on[i]) return i;
        end
        for (int i = 0; i < VOICES; i++) begin
            if (voice_ch[i] == ch && voice_nt[i] == {1'b0, note}) return i;
        end
        for (int i = 0; i < VOICES; i++) begin
            if (voice_ch[i] != ch) return i;
        end
        return 0;
    endfunction

    function automatic void key_on();
        logic [7:0] inst;
        logic [7:0] vol;
        logic       stolen;
        int         v;
        vol = chan_vol[pend_ch];
        if (pend_ch == 4'(PERC_CHANNEL)) begin
            inst = 8'(PERC_BASE + int'(pend_note) % PERC_MOD);
        end else begin
            inst = (chan_inst[pend_ch] > 8'd127) ? 8'd0 : chan_inst[pend_ch];
        end
        if (vol > 8'(VOL_MAX)) begin
            vol = 8'(VOL_MAX);
        end
        v = pick_voice(pend_ch, pend_note);
        stolen = voice_on[v];
        voice_on[v] = 1'b1;
        voice_ch[v] = pend_ch;
        voice_nt[v] = {1'b0, pend_note};
        add_result(KIND_KEY_ON, 4'(v), stolen, pend_ch, pend_note, vol[6:0], inst, '0);
    endfunction

    function automatic void predict_score_byte(input logic [7:0] b);
        logic [3:0]  ch;
        logic [63:0] acc;
        ch = pend_ch;
        byte_results.delete();
        case (parse_st)
            ST_EVENT: begin
                pend_last = b[7];
                pend_ch = b[3:0];
                case (b[6:4])
                    EV_RELEASE: parse_st = ST_REL_NOTE;
                    EV_PLAY:    parse_st = ST_PLAY_NOTE;
                    EV_PITCH:   parse_st = ST_PITCH_ARG;
                    EV_SYSTEM:  parse_st = ST_SYS_ARG;
                    EV_CONTROL: parse_st = ST_CTRL_NUM;
                    EV_MEASURE: end_event();
                    default: begin
                        // score end: loop, last bit dropped
                        add_result(KIND_LOOP, '0, 1'b0, b[3:0], '0, '0, '0, '0);
                        pend_last = 1'b0;
                        parse_st = ST_EVENT;
                    end
                endcase
            end
            ST_REL_NOTE: begin
                release_voices(ch, 1'b1, b[6:0]);
                end_event();
            end
            ST_PLAY_NOTE: begin
                pend_note = b[6:0];
                if (b[7]) begin
                    parse_st = ST_PLAY_VOL;
                end else begin
                    key_on();
                    end_event();
                end
            end
            ST_PLAY_VOL: begin
                chan_vol[ch] = b;
                key_on();
                end_event();
            end
            ST_PITCH_ARG: end_event();
            ST_SYS_ARG: begin
                if (b == SYS_OFF_A || b == SYS_OFF_B) begin
                    release_voices(ch, 1'b0, '0);
                end
                end_event();
            end
            ST_CTRL_NUM: begin
                pend_ctrl = b;
                parse_st = ST_CTRL_VAL;
            end
            ST_CTRL_VAL: begin
                if (pend_ctrl == CTRL_INSTR) begin
                    chan_inst[ch] = b;
                end else if (pend_ctrl == CTRL_VOLUME) begin
                    chan_vol[ch] = b;
                end
                end_event();
            end
            ST_DELAY: begin
                acc = 64'(delay_acc) * 64'd128 + 64'(b[6:0]);
                if (acc > DELAY_MAX) begin
                    acc = DELAY_MAX;
                end
                delay_acc = acc[27:0];
                if (!b[7]) begin
                    add_result(KIND_DELAY, '0, 1'b0, ch, '0, '0, '0, delay_acc);
                    delay_acc = '0;
                    pend_last = 1'b0;
                    parse_st = ST_EVENT;
                end
            end
            default: parse_st = ST_EVENT;
        endcase
        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].last = 1'b1;
        end
        foreach (byte_results[i]) begin
            expected_events.push_back(byte_results[i]);
        end
    endfunction

    // ---------------- stimulus helpers ----------------

    // mostly no gap, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] ev(input logic last, input logic [2:0] etype,
                                      input logic [3:0] ch);
        return {last, etype, ch};
    endfunction

    function automatic logic [3:0] pick_channel();
        return ($urandom_range(0, 4) == 0) ? 4'(PERC_CHANNEL) : 4'($urandom_range(0, 15));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(((bytes_sent / 40) % 4) == 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predict_score_byte(b);
        bytes_sent++;
    endtask

    task automatic send_play(input logic last, input logic [3:0] ch, input logic [6:0] note,
                             input logic with_vol);
        send_byte(ev(last, EV_PLAY, ch));
        send_byte({with_vol, note});
        if (with_vol) begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_delay();
        int  n;
        bit  sat;
        sat = ($urandom_range(0, 9) == 0);
        n = sat ? $urandom_range(4, 6) : $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            send_byte({i != n - 1, sat ? 7'h7F : 7'($urandom)});
        end
    endtask

    // hold input until the block has delivered everything owed
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---------------- tests ----------------

    task automatic test_event_decode();
        send_byte(ev(1'b0, EV_CONTROL, 4'd3));
        send_byte(CTRL_INSTR);
        send_byte(8'd200);                      // instrument above 127 reads as 0
        send_byte(ev(1'b0, EV_CONTROL, 4'd3));
        send_byte(CTRL_VOLUME);
        send_byte(8'd255);                      // volume clamps to 127
        send_play(1'b0, 4'd3, 7'd0, 1'b0);
        send_byte(ev(1'b0, EV_PLAY, 4'(PERC_CHANNEL)));
        send_byte(8'hFF);                       // note 127, volume byte follows
        send_byte(8'd0);
        send_byte(ev(1'b0, EV_PITCH, 4'd3));
        send_byte(8'hAA);
        send_byte(ev(1'b0, EV_RELEASE, 4'd3));  // note not held: no item
        send_byte(8'd5);
        send_byte(ev(1'b1, EV_RELEASE, 4'd3));
        send_byte(8'd0);
        send_byte(8'd0);                        // zero delay still reported
        send_byte(ev(1'b0, EV_SYSTEM, 4'(PERC_CHANNEL)));
        send_byte(8'd5);
        send_byte(ev(1'b0, EV_SYSTEM, 4'(PERC_CHANNEL)));
        send_byte(SYS_OFF_B);
        send_byte(ev(1'b1, EV_MEASURE, 4'd0));
        repeat (4) send_byte(8'hFF);            // delay saturates
        send_byte(8'h7F);
        send_byte(ev(1'b1, EV_END_A, 4'd2));    // last bit ignored on score end
        send_byte(ev(1'b0, EV_END_B, 4'd5));
    endtask

    task automatic test_random_score(input int target);
        int          r;
        int          held[$];
        int          k;
        logic        last;
        logic [3:0]  ch;
        logic [6:0]  note;
        logic [2:0]  etype;
        while (bytes_sent < target) begin
            r = $urandom_range(0, 99);
            last = ($urandom_range(0, 3) == 0);
            ch = pick_channel();
            note = 7'($urandom);
            if (r < 35) begin
                send_play(last, ch, note, $urandom_range(0, 2) == 0);
            end else if (r < 55) begin
                held.delete();
                foreach (voice_on[i]) if (voice_on[i]) held.push_back(i);
                if (held.size() > 0 && $urandom_range(0, 3) != 0) begin
                    k = held[$urandom_range(0, held.size() - 1)];
                    ch = voice_ch[k];
                    note = voice_nt[k][6:0];
                end
                send_byte(ev(last, EV_RELEASE, ch));
                send_byte({1'($urandom), note});  // top bit of the note byte is ignored
            end else if (r < 65) begin
                send_byte(ev(last, EV_CONTROL, ch));
                case ($urandom_range(0, 2))
                    0: send_byte(CTRL_INSTR);
                    1: send_byte(CTRL_VOLUME);
                    default: send_byte(8'($urandom));
                endcase
                send_byte(8'($urandom));
            end else if (r < 73) begin
                send_byte(ev(last, EV_SYSTEM, ch));
                case ($urandom_range(0, 2))
                    0: send_byte(SYS_OFF_A);
                    1: send_byte(SYS_OFF_B);
                    default: send_byte(8'($urandom));
                endcase
            end else if (r < 78) begin
                send_byte(ev(last, EV_PITCH, ch));
                send_byte(8'($urandom));
            end else if (r < 83) begin
                send_byte(ev(last, EV_MEASURE, ch));
            end else if (r < 87) begin
                etype = $urandom_range(0, 1) ? EV_END_A : EV_END_B;
                send_byte(ev(last, etype, ch));
                last = 1'b0;
            end else if (r < 94) begin
                // stray byte, may knock the parser off the event boundary
                send_byte(8'($urandom));
                last = 1'b0;
            end else begin
                send_play(last, ch, note, 1'b1);
            end
            if (last) begin
                send_delay();
            end
        end
    endtask

    // chords mostly on one channel, with stray notes on others, to fill the voice table and force steals
    task automatic test_voice_pressure(input int target);
        logic [3:0] ch;
        logic [6:0] base;
        int         chord;
        int         spread;
        while (bytes_sent < target) begin
            ch = pick_channel();
            spread = $urandom_range(0, 1) ? 4 : 20;
            base = 7'($urandom_range(0, 127 - spread));
            chord = $urandom_range(8, 13);
            for (int i = 0; i < chord; i++) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_play(1'b0, pick_channel(), 7'($urandom), 1'b0);
                end else begin
                    send_play(1'b0, ch, base + 7'($urandom_range(0, spread)),
                              $urandom_range(0, 3) == 0);
                end
            end
            case ($urandom_range(0, 3))
                0: begin
                    send_byte(ev(1'b0, EV_SYSTEM, ch));
                    send_byte(SYS_OFF_A);
                end
                1: begin
                    send_byte(ev(1'b1, EV_SYSTEM, ch));
                    send_byte(SYS_OFF_B);
                    send_delay();
                end
                2: begin
                    send_byte(ev(1'b0, EV_RELEASE, ch));
                    send_byte({1'b0, base});
                end
                default: ;
            endcase
        end
    endtask

    // ---------------- output side ----------------

    initial begin : drive_ready
        int pass;
        int stall;
        m_tready = 1'b0;
        pass = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = pick_gap(((pass / 32) % 4) == 2);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            pass++;
        end
    end

    function automatic string fmt_result(input seq_result_t r);
        return $sformatf({"kind=%0d voice=%0d stolen=%0b ch=%0d note=%0d vol=%0d",
                          " inst=%0d ticks=%0d last=%0b"},
                         r.kind, r.voice, r.stolen, r.chan, r.note, r.vol, r.inst, r.ticks,
                         r.last);
    endfunction

    always @(posedge aclk) begin : check_results
        seq_result_t got;
        seq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kind_t'(m_tuser), m_tdata[3:0], m_tdata[4], m_tdata[8:5], m_tdata[15:9],
                    m_tdata[22:16], m_tdata[30:23], m_tdata[58:31], m_tlast};
            results_seen++;
            case (got.kind)
                KIND_KEY_ON: begin
                    n_key_on++;
                    if (got.stolen) n_steal++;
                end
                KIND_KEY_OFF: n_key_off++;
                KIND_DELAY:   n_delay++;
                default:      n_loop++;
            endcase
            if (expected_events.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: unexpected item %s", $realtime, fmt_result(got));
                end
            end else begin
                want = expected_events.pop_front();
                if (got !== want || m_tdata[63:59] !== 5'd0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: mismatch on item %0d (pad=%h)", $realtime,
                                 results_seen, m_tdata[63:59]);
                        $display("    expected %s", fmt_result(want));
                        $display("    actual   %s", fmt_result(got));
                    end
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        parse_st = ST_EVENT;
        pend_ch = '0;
        pend_note = '0;
        pend_last = 1'b0;
        pend_ctrl = '0;
        delay_acc = '0;
        foreach (chan_inst[i]) begin
            chan_inst[i] = '0;
            chan_vol[i]  = 8'(VOL_RESET);
        end
        foreach (voice_on[i]) begin
            voice_on[i] = 1'b0;
            voice_ch[i] = '0;
            voice_nt[i] = '0;
        end
        bytes_sent = 0;
        results_seen = 0;
        fail_count = 0;
        n_key_on = 0;
        n_steal = 0;
        n_key_off = 0;
        n_delay = 0;
        n_loop = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_event_decode();
        wait_drained();
        test_random_score(bytes_sent + 240);
        wait_drained();
        test_voice_pressure(bytes_sent + 120);
        wait_drained();

        $display("Sent %0d score bytes; checked %0d items: %0d key-ons (%0d on busy voices),",
                 bytes_sent, results_seen, n_key_on, n_steal);
        $display("%0d key-offs, %0d delays, %0d loops; %0d failures",
                 n_key_off, n_delay, n_loop, fail_count);
        if (fail_count == 0) begin
            $display("tb_mus_event_voice_sequencer: PASS");
        end else begin
            $display("tb_mus_event_voice_sequencer: FAIL");
        end
        $finish;
    end

endmodule
